[sv/dtf_pkg.sv]
// Package: token, phase and status types plus constants for the decimal text parser.
`timescale 1ns / 1ps
`default_nettype none
package dtf_pkg;

	localparam int CH_W      = 8;
	localparam int DIGIT_W   = 4;
	localparam int LIMIT_W   = 25;
	localparam int VALUE_W   = 26;
	localparam int STATUS_W  = 2;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int FIFO_DEPTH = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd20000000;
	localparam logic ADDR_REG_LIMIT = 1'b0;

	typedef enum logic [2:0] {
		TK_WS,
		TK_PLUS,
		TK_MINUS,
		TK_DIGIT,
		TK_POINT,
		TK_END,
		TK_OTHER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t            kind;
		logic [DIGIT_W-1:0]   digit;
	} token_t;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SIGN,
		PH_INT,
		PH_FRAC,
		PH_TRAIL
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	// powers of ten, saturating at 1e9
	function automatic logic [31:0] pow10(input logic [3:0] e);
		logic [31:0] r;
		unique case (e)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			default: r = 32'd1000000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/dtf_if.sv]
// Interfaces: character request channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface dtf_in_if;
	logic                      valid;
	logic                      ready;
	logic [dtf_pkg::CH_W-1:0]  ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface dtf_out_if;
	logic                             valid;
	logic                             ready;
	logic [dtf_pkg::STATUS_W-1:0]     status;
	logic signed [dtf_pkg::VALUE_W-1:0] value;

	modport source (output valid, output status, output value, input ready);
	modport sink (input valid, input status, input value, output ready);
endinterface
`default_nettype wire

[sv/dtf_front.sv]
// Front end: takes characters and classifies each into a token.
`timescale 1ns / 1ps
`default_nettype none
module dtf_front (
	dtf_in_if.sink           chars,
	output logic             tok_valid,
	input  logic             tok_ready,
	output dtf_pkg::token_t  tok
);

	logic [dtf_pkg::CH_W-1:0] c;

	assign c           = chars.ch;
	assign tok_valid   = chars.valid;
	assign chars.ready = tok_ready;

	always_comb begin
		tok.digit = c[dtf_pkg::DIGIT_W-1:0];
		priority if (c == 8'd0) begin
			tok.kind = dtf_pkg::TK_END;
		end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
			tok.kind = dtf_pkg::TK_WS;
		end else if (c == 8'h2B) begin
			tok.kind = dtf_pkg::TK_PLUS;
		end else if (c == 8'h2D) begin
			tok.kind = dtf_pkg::TK_MINUS;
		end else if (c == 8'h2E) begin
			tok.kind = dtf_pkg::TK_POINT;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			tok.kind = dtf_pkg::TK_DIGIT;
		end else begin
			tok.kind = dtf_pkg::TK_OTHER;
		end
	end

endmodule
`default_nettype wire

[sv/dtf_fifo.sv]
// Two-entry token queue between front end and parser.
`timescale 1ns / 1ps
`default_nettype none
module dtf_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  dtf_pkg::token_t  push_tok,
	output logic             pop_valid,
	input  logic             pop_ready,
	output dtf_pkg::token_t  pop_tok
);

	localparam int PTR_W = $clog2(dtf_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(dtf_pkg::FIFO_DEPTH + 1);

	dtf_pkg::token_t     mem_q [dtf_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != CNT_W'(dtf_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule
`default_nettype wire

[sv/dtf_back.sv]
// Back end: parse state machine, fraction accumulation and result register.
`timescale 1ns / 1ps
`default_nettype none
module dtf_back #(
	parameter int FRACTION_DIGITS = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tok_valid,
	output logic                              tok_ready,
	input  dtf_pkg::token_t                   tok,
	input  logic [dtf_pkg::LIMIT_W-1:0]       limit,
	dtf_out_if.source                         results
);

	localparam longint unsigned MAG_MAX =
		64'(3) * 64'(dtf_pkg::pow10(4'(FRACTION_DIGITS)));
	localparam int MAG_W = $clog2(MAG_MAX + 1);
	localparam int CNT_W = $clog2(FRACTION_DIGITS + 2);
	localparam int CMP_W = (MAG_W > dtf_pkg::LIMIT_W) ? MAG_W : dtf_pkg::LIMIT_W;
	localparam int EXT_W = (MAG_W > dtf_pkg::VALUE_W) ? MAG_W : dtf_pkg::VALUE_W;
	localparam int PROD_W = 36;

	dtf_pkg::phase_t          phase_q, phase_d;
	logic                     neg_q, neg_d;
	logic [MAG_W-1:0]         mag_q, mag_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic                     bad_q, bad_d;

	logic                     out_valid_q;
	dtf_pkg::status_t         status_q, status_d;
	logic [dtf_pkg::VALUE_W-1:0] value_q, value_d;

	logic                     take;
	logic                     emit;
	logic                     out_free;
	logic                     is_int_digit;
	logic [31:0]              frac_weight;
	logic [PROD_W-1:0]        int_prod;
	logic [PROD_W-1:0]        frac_prod;
	logic [EXT_W-1:0]         mag_ext;
	logic [dtf_pkg::VALUE_W-1:0] mag_v;
	logic                     over;

	assign out_free     = !out_valid_q || results.ready;
	assign tok_ready    = (tok.kind != dtf_pkg::TK_END) || out_free;
	assign take         = tok_valid && tok_ready;
	assign emit         = take && (tok.kind == dtf_pkg::TK_END);
	assign is_int_digit = (tok.kind == dtf_pkg::TK_DIGIT) && (tok.digit <= 4'd2);

	assign frac_weight = dtf_pkg::pow10(4'(FRACTION_DIGITS - 1) - 4'(cnt_q));
	assign int_prod    = PROD_W'(tok.digit) *
		PROD_W'(dtf_pkg::pow10(4'(FRACTION_DIGITS)));
	assign frac_prod   = PROD_W'(tok.digit) * PROD_W'(frac_weight);

	assign mag_ext = EXT_W'(mag_q);
	assign mag_v   = mag_ext[dtf_pkg::VALUE_W-1:0];
	assign over    = CMP_W'(mag_q) > CMP_W'(limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dtf_pkg::PH_LEAD;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			cnt_q       <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				mag_q   <= mag_d;
				cnt_q   <= cnt_d;
				bad_q   <= bad_d;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= status_d;
			value_q  <= value_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		neg_d    = neg_q;
		mag_d    = mag_q;
		cnt_d    = cnt_q;
		bad_d    = bad_q;
		status_d = dtf_pkg::ST_OK;
		value_d  = '0;

		if (tok.kind == dtf_pkg::TK_END) begin
			priority if (bad_q || phase_q == dtf_pkg::PH_LEAD || phase_q == dtf_pkg::PH_SIGN) begin
				status_d = dtf_pkg::ST_MALFORMED;
			end else if (over) begin
				status_d = dtf_pkg::ST_RANGE;
			end else begin
				status_d = dtf_pkg::ST_OK;
				value_d  = neg_q ? (-mag_v) : mag_v;
			end
			phase_d = dtf_pkg::PH_LEAD;
			neg_d   = 1'b0;
			mag_d   = '0;
			cnt_d   = '0;
			bad_d   = 1'b0;
		end else if (!bad_q) begin
			unique case (phase_q)
				dtf_pkg::PH_LEAD: begin
					priority if (tok.kind == dtf_pkg::TK_WS) begin
						phase_d = dtf_pkg::PH_LEAD;
					end else if (tok.kind == dtf_pkg::TK_PLUS || tok.kind == dtf_pkg::TK_MINUS) begin
						neg_d   = (tok.kind == dtf_pkg::TK_MINUS);
						phase_d = dtf_pkg::PH_SIGN;
					end else if (is_int_digit) begin
						mag_d   = MAG_W'(int_prod);
						phase_d = dtf_pkg::PH_INT;
					end else begin
						bad_d = 1'b1;
					end
				end
				dtf_pkg::PH_SIGN: begin
					if (is_int_digit) begin
						mag_d   = MAG_W'(int_prod);
						phase_d = dtf_pkg::PH_INT;
					end else begin
						bad_d = 1'b1;
					end
				end
				dtf_pkg::PH_INT: begin
					priority if (tok.kind == dtf_pkg::TK_POINT) begin
						phase_d = dtf_pkg::PH_FRAC;
					end else if (tok.kind == dtf_pkg::TK_WS) begin
						phase_d = dtf_pkg::PH_TRAIL;
					end else begin
						bad_d = 1'b1;
					end
				end
				dtf_pkg::PH_FRAC: begin
					priority if (tok.kind == dtf_pkg::TK_DIGIT) begin
						priority if (cnt_q < CNT_W'(FRACTION_DIGITS)) begin
							cnt_d = cnt_q + 1'b1;
							mag_d = mag_q + MAG_W'(frac_prod);
						end else if (cnt_q == CNT_W'(FRACTION_DIGITS)) begin
							// rounding digit
							cnt_d = cnt_q + 1'b1;
							if (tok.digit >= 4'd5) begin
								mag_d = mag_q + 1'b1;
							end
						end else begin
							cnt_d = cnt_q;
						end
					end else if (tok.kind == dtf_pkg::TK_WS) begin
						phase_d = dtf_pkg::PH_TRAIL;
					end else begin
						bad_d = 1'b1;
					end
				end
				default: begin
					if (tok.kind != dtf_pkg::TK_WS) begin
						bad_d = 1'b1;
					end
				end
			endcase
		end
	end

	assign results.valid  = out_valid_q;
	assign results.status = status_q;
	assign results.value  = value_q;

endmodule
`default_nettype wire

[sv/decimal_text_to_fixed_point_top.sv]
// Top level: decimal text to signed fixed point converter with APB limit register.
//
// Accepts one character per clock on chars while the token queue has room, and
// returns one result per zero byte on results. A zero byte's result passes
// through the two-entry token queue and then the parser's result register.
// Characters keep flowing while a result waits; only a second terminator behind
// an unread result holds the queue. The limit register sits at byte address 0
// and resets to 20000000 (units of 1e-7).
`timescale 1ns / 1ps
`default_nettype none
module decimal_text_to_fixed_point_top #(
	parameter int FRACTION_DIGITS = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dtf_in_if.sink                            chars,
	dtf_out_if.source                         results,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dtf_pkg::ADDR_W-1:0]        paddr,
	input  logic [dtf_pkg::DATA_W-1:0]        pwdata,
	output logic [dtf_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	logic [dtf_pkg::LIMIT_W-1:0] limit_q;
	logic                        hit_limit;

	logic                        f_valid;
	logic                        f_ready;
	dtf_pkg::token_t             f_tok;
	logic                        b_valid;
	logic                        b_ready;
	dtf_pkg::token_t             b_tok;

	assign pready    = 1'b1;
	assign hit_limit = (paddr[2] == dtf_pkg::ADDR_REG_LIMIT);
	assign prdata    = hit_limit ? dtf_pkg::DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= dtf_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && hit_limit) begin
			limit_q <= pwdata[dtf_pkg::LIMIT_W-1:0];
		end
	end

	dtf_front u_front (
		.chars     (chars),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	dtf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_tok   (f_tok),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_tok    (b_tok)
	);

	dtf_back #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (b_valid),
		.tok_ready (b_ready),
		.tok       (b_tok),
		.limit     (limit_q),
		.results   (results)
	);

endmodule
`default_nettype wire

[sv/dtf_checker.sv]
// Checker: port-level assertions for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dtf_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [dtf_pkg::STATUS_W-1:0]        out_status,
	input  logic signed [dtf_pkg::VALUE_W-1:0]  out_value,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dtf_pkg::ADDR_W-1:0]          paddr,
	input  logic [dtf_pkg::DATA_W-1:0]          pwdata,
	input  logic [dtf_pkg::DATA_W-1:0]          prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != dtf_pkg::ST_OK |-> out_value == '0)
		else $error("nonzero value on failed conversion");

	a_ok_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == dtf_pkg::ST_OK |->
			out_value <= 26'sd30000000 && out_value >= -26'sd30000000)
		else $error("converted value out of representable range");

	a_limit_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == dtf_pkg::ADDR_REG_LIMIT) ##1
		(psel && !pwrite && paddr[2] == dtf_pkg::ADDR_REG_LIMIT) |->
			prdata == dtf_pkg::DATA_W'($past(pwdata[dtf_pkg::LIMIT_W-1:0])))
		else $error("limit readback mismatch");

endmodule

bind decimal_text_to_fixed_point_top dtf_checker u_dtf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_status (results.status),
	.out_value  (results.value),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata)
);
`default_nettype wire
